// File: rtl/core/cblru_pkg.sv
// Shared types and constants for the size-aware LRU cache core.
`timescale 1ns / 1ps
package cblru_pkg;

  localparam int SIZE_W   = 31;
  localparam int TOTAL_W  = 35;
  localparam int BUDGET_W = 32;
  localparam int KIND_W   = 2;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 32'd1000;

  localparam logic CMD_USE    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [KIND_W-1:0] KIND_BUDGET = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FORCED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              take_req;
    logic              inc_idx;
    logic              tail_sel;
    logic              unlink;
    logic              evict_tail;
    logic              insert;
    logic              load_out;
    logic [KIND_W-1:0] out_kind;
    logic              out_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_remove;
    logic hit;
    logic at_end;
    logic full;
    logic more;
  } dp_stat_t;

endpackage

// File: rtl/core/cblru_chan_if.sv
// Channel interfaces for requests, results and the budget register write.
`timescale 1ns / 1ps
interface cblru_req_if #(parameter int ID_W = 16);
  logic            valid;
  logic            ready;
  logic            command;
  logic [ID_W-1:0] object_id;
  logic [30:0]     object_size;
  modport source (output valid, command, object_id, object_size, input ready);
  modport sink   (input valid, command, object_id, object_size, output ready);
endinterface

interface cblru_res_if #(parameter int ID_W = 16);
  logic            valid;
  logic            ready;
  logic [1:0]      kind;
  logic [ID_W-1:0] evicted_id;
  logic [34:0]     total_cost;
  logic [31:0]     budget;
  logic            last;
  modport source (output valid, kind, evicted_id, total_cost, budget, last, input ready);
  modport sink   (input valid, kind, evicted_id, total_cost, budget, last, output ready);
endinterface

interface cblru_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] budget_setting;
  modport source (output valid, budget_setting, input ready);
  modport sink   (input valid, budget_setting, output ready);
endinterface

// File: rtl/core/cost_bounded_lru_cache_core.sv
// Top level of the size-aware LRU cache core: controller plus datapath.
// Requests are handled one at a time: a new one is accepted only once the last result of the
//   previous one has been taken. Processing time is set by the serial list search and the tail
//   eviction walk.
// Reset: synchronous active-low; clears the list count and total, budget becomes 1000.
`timescale 1ns / 1ps
module cost_bounded_lru_cache_core #(
  parameter int CAPACITY = 16,
  parameter int ID_BITS  = 16
) (
  input logic        clk,
  input logic        rst_n,
  cblru_req_if.sink  in_if,
  cblru_res_if.source out_if,
  cblru_cfg_if.sink  cfg_if
);
  import cblru_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The budget register may be written at any time the core is idle, so the
  // configuration channel is always ready.
  assign cfg_if.ready = 1'b1;

  // The controller walks each transaction through search and unlink; a use then
  // goes on to an optional forced eviction when the list is full, insertion at
  // the front, and the budget eviction loop. Each result is staged in an output
  // register and held until the sink takes it.
  cblru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the most-recent-first list in shifting registers,
  // the running total and the working budget.
  cblru_dp #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .req_command (in_if.command),
    .req_id      (in_if.object_id),
    .req_size    (in_if.object_size),
    .cfg_we      (cfg_if.valid),
    .cfg_budget  (cfg_if.budget_setting),
    .out_kind    (out_if.kind),
    .out_id      (out_if.evicted_id),
    .out_total   (out_if.total_cost),
    .out_budget  (out_if.budget),
    .out_last    (out_if.last)
  );

endmodule

// File: rtl/core/cblru_ctrl.sv
// Controller state machine that sequences search, unlink, insert and eviction.
`timescale 1ns / 1ps
module cblru_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  cblru_pkg::dp_stat_t stat,
  output cblru_pkg::dp_cmd_t  cmd
);
  import cblru_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SEARCH = 4'd1;
  localparam logic [3:0] S_UNLINK = 4'd2;
  localparam logic [3:0] S_FULL   = 4'd3;
  localparam logic [3:0] S_INSERT = 4'd4;
  localparam logic [3:0] S_DECIDE = 4'd5;
  localparam logic [3:0] S_EVICT  = 4'd6;
  localparam logic [3:0] S_EVCHK  = 4'd7;
  localparam logic [3:0] S_RDONE  = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       forced_r, forced_nxt;
  logic       cont_r, cont_nxt;

  always_comb begin
    state_nxt  = state_r;
    forced_nxt = forced_r;
    cont_nxt   = cont_r;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_req = 1'b1;
          forced_nxt   = 1'b0;
          state_nxt    = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.at_end) begin
          state_nxt = stat.is_remove ? S_RDONE : S_FULL;
        end else if (stat.hit) begin
          state_nxt = S_UNLINK;
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_nxt  = stat.is_remove ? S_RDONE : S_FULL;
      end
      S_FULL: begin
        if (stat.full) begin
          cmd.tail_sel   = 1'b1;
          cmd.evict_tail = 1'b1;
          forced_nxt     = 1'b1;
        end
        state_nxt = S_INSERT;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = S_DECIDE;
      end
      S_DECIDE: begin
        if (forced_r) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = KIND_FORCED;
          cmd.out_last = !stat.more;
          cont_nxt     = stat.more;
          state_nxt    = S_OUT;
        end else if (stat.more) begin
          state_nxt = S_EVICT;
        end else begin
          cmd.load_out = 1'b1;
          cmd.out_kind = KIND_DONE;
          cmd.out_last = 1'b1;
          cont_nxt     = 1'b0;
          state_nxt    = S_OUT;
        end
      end
      S_EVICT: begin
        cmd.tail_sel   = 1'b1;
        cmd.evict_tail = 1'b1;
        state_nxt      = S_EVCHK;
      end
      S_EVCHK: begin
        cmd.load_out = 1'b1;
        cmd.out_kind = KIND_BUDGET;
        cmd.out_last = !stat.more;
        cont_nxt     = stat.more;
        state_nxt    = S_OUT;
      end
      S_RDONE: begin
        cmd.load_out = 1'b1;
        cmd.out_kind = KIND_DONE;
        cmd.out_last = 1'b1;
        cont_nxt     = 1'b0;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = cont_r ? S_EVICT : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      forced_r <= 1'b0;
      cont_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      forced_r <= forced_nxt;
      cont_r   <= cont_nxt;
    end
  end

endmodule

// File: rtl/core/cblru_dp.sv
// Datapath: the recency list, running total, working budget and result register.
`timescale 1ns / 1ps
module cblru_dp #(
  parameter int CAPACITY = 16,
  parameter int ID_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cblru_pkg::dp_cmd_t             cmd,
  output cblru_pkg::dp_stat_t            stat,
  input  logic                           req_command,
  input  logic [ID_BITS-1:0]             req_id,
  input  logic [cblru_pkg::SIZE_W-1:0]   req_size,
  input  logic                           cfg_we,
  input  logic [cblru_pkg::BUDGET_W-1:0] cfg_budget,
  output logic [cblru_pkg::KIND_W-1:0]   out_kind,
  output logic [ID_BITS-1:0]             out_id,
  output logic [cblru_pkg::TOTAL_W-1:0]  out_total,
  output logic [cblru_pkg::BUDGET_W-1:0] out_budget,
  output logic                           out_last
);
  import cblru_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic [ID_BITS-1:0]  ids_r   [CAPACITY];
  logic [SIZE_W-1:0]   sizes_r [CAPACITY];
  logic [CW-1:0]       count_r, idx_r;
  logic [TOTAL_W-1:0]  total_r, ev_total_r;
  logic [BUDGET_W-1:0] budget_r;
  logic                cmd_r;
  logic [ID_BITS-1:0]  id_r, ev_id_r;
  logic [SIZE_W-1:0]   size_r;
  logic [CW-1:0]       tail_pos;
  logic [IW-1:0]       rd_addr;
  logic [ID_BITS-1:0]  rd_id;
  logic [SIZE_W-1:0]   rd_size;
  logic [BUDGET_W-1:0] twice_size;

  assign tail_pos   = count_r - CW'(1);
  assign rd_addr    = cmd.tail_sel ? tail_pos[IW-1:0] : idx_r[IW-1:0];
  assign rd_id      = ids_r[rd_addr];
  assign rd_size    = sizes_r[rd_addr];
  assign twice_size = {size_r, 1'b0};

  assign stat.is_remove = (cmd_r == CMD_REMOVE);
  assign stat.hit       = (rd_id == id_r);
  assign stat.at_end    = (idx_r == count_r);
  assign stat.full      = (count_r == CW'(CAPACITY));
  assign stat.more      = (total_r > {{(TOTAL_W-BUDGET_W){1'b0}}, budget_r})
                          && (count_r > CW'(1));

  // List storage shifts in place; only entries below the count are ever read.
  always_ff @(posedge clk) begin
    if (cmd.unlink) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (CW'(i) >= idx_r) begin
          ids_r[i]   <= ids_r[i+1];
          sizes_r[i] <= sizes_r[i+1];
        end
      end
    end else if (cmd.insert) begin
      for (int i = 1; i < CAPACITY; i++) begin
        ids_r[i]   <= ids_r[i-1];
        sizes_r[i] <= sizes_r[i-1];
      end
      ids_r[0]   <= id_r;
      sizes_r[0] <= size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      total_r  <= '0;
      budget_r <= BUDGET_RESET;
      idx_r    <= '0;
    end else begin
      if (cfg_we) begin
        budget_r <= cfg_budget;
      end
      if (cmd.take_req) begin
        idx_r <= '0;
      end else if (cmd.inc_idx) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.unlink || cmd.evict_tail) begin
        count_r <= count_r - CW'(1);
        total_r <= total_r - {{(TOTAL_W-SIZE_W){1'b0}}, rd_size};
      end else if (cmd.insert) begin
        count_r <= count_r + CW'(1);
        total_r <= total_r + {{(TOTAL_W-SIZE_W){1'b0}}, size_r};
        if (twice_size > budget_r) begin
          budget_r <= twice_size;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_req) begin
      cmd_r  <= req_command;
      id_r   <= req_id;
      size_r <= req_size;
    end
    if (cmd.evict_tail) begin
      ev_id_r    <= rd_id;
      ev_total_r <= total_r - {{(TOTAL_W-SIZE_W){1'b0}}, rd_size};
    end
    if (cmd.load_out) begin
      out_kind   <= cmd.out_kind;
      out_last   <= cmd.out_last;
      out_budget <= budget_r;
      if (cmd.out_kind == KIND_DONE) begin
        out_id    <= '0;
        out_total <= total_r;
      end else begin
        out_id    <= ev_id_r;
        out_total <= ev_total_r;
      end
    end
  end

endmodule
